// ===== hdl/lphi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert package
// Shared sizes, codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package lphi_pkg;

    localparam int TABLE_SIZE = 128;
    localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = SLOT_W + 1;
    localparam bit IS_POW2    = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    localparam int KEY_W      = 31;
    localparam int PAY_W      = 64;
    localparam int IDX_W      = 7;
    localparam int STAT_W     = 2;

    // Reciprocal of the table size for the home slot unit. With this shift
    // the estimated quotient is never more than one below the true one.
    localparam int          RECIP_SH = KEY_W + SLOT_W;
    localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / TABLE_SIZE);

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADKEY = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RDATA
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the input beat and start hashing
        logic probe_step;    // advance to the next slot
        logic write_slot;    // store the record at the current slot
        logic rd_issue;      // read the slot named by the read beat
        logic res_insert;    // post a successful insert result
        logic res_full;      // post a table-full result
        logic res_badkey;    // post an invalid-key result
        logic res_read;      // post a slot read result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic key_zero;
        logic hash_busy;
        logic slot_free;
        logic probe_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/lphi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface lphi_req_if;
    import lphi_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [IDX_W-1:0] slot_index;

    modport source (output valid, command, key, payload, slot_index, input ready);
    modport sink   (input valid, command, key, payload, slot_index, output ready);
endinterface

interface lphi_res_if;
    import lphi_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slot_used;
    logic              occupied;
    logic [KEY_W-1:0]  key_out;
    logic [PAY_W-1:0]  payload_out;

    modport source (output valid, status, slot_used, occupied, key_out, payload_out,
                    input ready);
    modport sink   (input valid, status, slot_used, occupied, key_out, payload_out,
                    output ready);
endinterface

// ===== hdl/lphi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert controller
// Sequences hashing, probing and slot reads, one request at a time.
// ----------------------------------------------------------------------------
module lphi_ctrl
    import lphi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.is_read) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RDATA;
                end else if (i_stat.key_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.res_badkey = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (!i_stat.hash_busy) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_stat.slot_free) begin
                    if (i_stat.out_free) begin
                        o_cmd.write_slot = 1'b1;
                        o_cmd.res_insert = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.probe_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.res_full = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.probe_step = 1'b1;
                end
            end
            S_RDATA: begin
                if (i_stat.out_free) begin
                    o_cmd.res_read = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lphi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert datapath
// Request registers, home slot unit, probe pointer, slot stores and result.
// ----------------------------------------------------------------------------
module lphi_datapath
    import lphi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_command,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [PAY_W-1:0]  i_payload,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_slot_used,
    output logic              o_occupied,
    output logic [KEY_W-1:0]  o_key_out,
    output logic [PAY_W-1:0]  o_payload_out
);

    // Captured request.
    logic             r_command;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;
    logic [IDX_W-1:0] r_idx;

    // Home slot unit: key modulo table size. A power-of-two size is a mask;
    // otherwise a registered reciprocal multiply, then a reduction with
    // one conditional subtract in the cycle after it.
    logic                r_hash_busy;
    logic                r_hash_ph;
    logic [KEY_W+31:0]   r_prod;
    logic [KEY_W-1:0]    w_quot;
    logic [SLOT_W:0]     w_rem_raw;
    logic [SLOT_W-1:0]   w_rem_next;

    // Probe pointer and count of slots already examined.
    logic [SLOT_W-1:0] r_pos;
    logic [CNT_W-1:0]  r_cnt;

    // Slot stores; the valid bits stand for nonzero keys.
    logic [TABLE_SIZE-1:0] r_valid;
    logic [KEY_W-1:0]      r_key_mem [TABLE_SIZE];
    logic [PAY_W-1:0]      r_pay_mem [TABLE_SIZE];
    logic [KEY_W-1:0]      r_rd_key;
    logic [PAY_W-1:0]      r_rd_pay;
    logic                  r_rd_occ;
    logic [SLOT_W-1:0]     w_rd_addr;
    logic                  w_rd_in_range;

    // Result register.
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_slot_used;
    logic              r_occupied;
    logic [KEY_W-1:0]  r_key_out;
    logic [PAY_W-1:0]  r_payload_out;

    // The remainder lies below twice the table size, so only its low bits
    // need to be formed.
    always_comb begin
        w_quot    = KEY_W'(r_prod >> RECIP_SH);
        w_rem_raw = (SLOT_W + 1)'(r_key) -
                    (SLOT_W + 1)'(w_quot) * (SLOT_W + 1)'(TABLE_SIZE);
        if (w_rem_raw >= (SLOT_W + 1)'(TABLE_SIZE)) begin
            w_rem_next = SLOT_W'(w_rem_raw - (SLOT_W + 1)'(TABLE_SIZE));
        end else begin
            w_rem_next = SLOT_W'(w_rem_raw);
        end
    end

    assign w_rd_addr     = SLOT_W'(r_idx);
    assign w_rd_in_range = (32'(r_idx) < 32'(TABLE_SIZE));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_key     <= i_key;
            r_payload <= i_payload;
            r_idx     <= i_slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_busy <= 1'b0;
            r_hash_ph   <= 1'b0;
        end else if (i_cmd.load) begin
            r_hash_busy <= !IS_POW2;
            r_hash_ph   <= 1'b0;
        end else if (r_hash_busy) begin
            r_hash_ph <= 1'b1;
            if (r_hash_ph) begin
                r_hash_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hash_busy && !r_hash_ph) begin
            r_prod <= {32'd0, r_key} * {31'd0, RECIP};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= '0;
            if (IS_POW2) begin
                r_pos <= i_key[SLOT_W-1:0];
            end
        end else if (r_hash_busy && r_hash_ph) begin
            r_pos <= w_rem_next;
        end else if (i_cmd.probe_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_pos == SLOT_W'(TABLE_SIZE - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write_slot) begin
            r_valid[r_pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_slot) begin
            r_key_mem[r_pos] <= r_key;
            r_pay_mem[r_pos] <= r_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_key <= r_key_mem[w_rd_addr];
            r_rd_pay <= r_pay_mem[w_rd_addr];
            r_rd_occ <= w_rd_in_range && r_valid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_insert || i_cmd.res_full || i_cmd.res_badkey ||
                     i_cmd.res_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_insert) begin
            r_status      <= ST_DONE;
            r_slot_used   <= IDX_W'(r_pos);
            r_occupied    <= 1'b1;
            r_key_out     <= r_key;
            r_payload_out <= r_payload;
        end else if (i_cmd.res_full || i_cmd.res_badkey) begin
            r_status      <= i_cmd.res_full ? ST_FULL : ST_BADKEY;
            r_slot_used   <= '0;
            r_occupied    <= 1'b0;
            r_key_out     <= '0;
            r_payload_out <= '0;
        end else if (i_cmd.res_read) begin
            r_status      <= ST_DONE;
            r_slot_used   <= r_idx;
            r_occupied    <= r_rd_occ;
            r_key_out     <= r_rd_occ ? r_rd_key : '0;
            r_payload_out <= r_rd_occ ? r_rd_pay : '0;
        end
    end

    always_comb begin
        o_stat.is_read    = (r_command == CMD_READ);
        o_stat.key_zero   = (r_key == '0);
        o_stat.hash_busy  = r_hash_busy;
        o_stat.slot_free  = !r_valid[r_pos];
        o_stat.probe_last = (r_cnt == CNT_W'(TABLE_SIZE - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_used   = r_slot_used;
    assign o_occupied    = r_occupied;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_payload_out;

endmodule

// ===== hdl/linear_probe_hash_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert
// Open-addressed hash table with linear probing, insert and slot read.
// ----------------------------------------------------------------------------
// The block holds TABLE_SIZE slots (128), each a 31-bit key and a 64-bit
// payload, and handles one request beat at a time. An insert hashes its key
// to the home slot (key modulo the table size), then probes forward one slot
// per cycle, wrapping at the end, and writes the record into the first empty
// slot. The accepted beat passes through the hash state, then the probe loop
// over the occupancy flags, into the result register. For a table size that
// is not a power of two the home slot unit adds a reciprocal multiply and a
// reduction step. An insert of key zero returns the invalid-key status from
// the hash state, and an insert into a full table returns table full once
// every slot has been probed. A read beat returns the occupied flag, key and
// payload of one slot through the registered read port of the slot stores.
// A new request beat is taken as soon as the block is back in idle, even
// while the previous result beat still waits in the output register. Reset
// empties the table at once through per-slot occupancy flags; no clearing
// pass is needed, and the payload store is never shown for an empty slot.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert
    import lphi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    lphi_req_if.sink   i_req,
    lphi_res_if.source o_res
);

    // Command and status between the controller and the datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller owns the request ready and all sequencing decisions.
    lphi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the table, the probe state and the result register.
    lphi_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (i_req.command),
        .i_key         (i_req.key),
        .i_payload     (i_req.payload),
        .i_slot_index  (i_req.slot_index),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_status      (o_res.status),
        .o_slot_used   (o_res.slot_used),
        .o_occupied    (o_res.occupied),
        .o_key_out     (o_res.key_out),
        .o_payload_out (o_res.payload_out)
    );

endmodule
